@@ src/kmd_pkg.sv @@
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared constants and types of the key matrix debounce and event packer.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

	// Matrix size and time base.
	localparam int KEY_COUNT   = 12;
	localparam int TIME_BITS   = 32;
	localparam int KEY_W       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	// Port widths fixed by the word formats.
	localparam int SCAN_TIME_W = 32;
	localparam int RAW_W       = 12;
	localparam int DEB_W       = 16;
	localparam int ID_W        = 8;
	localparam int FRAME_W     = 48;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;

	// Width at which elapsed time and debounce time are compared.
	localparam int CMP_W = (TIME_BITS > DEB_W) ? TIME_BITS : DEB_W;

	// Frame bytes.
	localparam logic [7:0] FRAME_START = 8'hAA;
	localparam logic [7:0] FRAME_TYPE  = 8'h01;
	localparam logic [7:0] FRAME_PAD   = 8'h00;

	// Register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ID_OFFSET = CFG_IDX_W'(1);
	localparam logic [DEB_W-1:0]     DEBOUNCE_RESET    = DEB_W'(20);
	localparam logic [ID_W-1:0]      KEY_OFFSET_RESET  = ID_W'(2);

	// One entry of the per-key state memory.
	typedef struct packed {
		logic                 raw_seen;
		logic                 stable;
		logic [TIME_BITS-1:0] change_time;
	} key_entry_t;

	// One event handed to the output register.
	typedef struct packed {
		logic [ID_W-1:0] key_id;
		logic            pressed;
		logic            last;
	} key_event_t;

endpackage

`default_nettype wire

@@ src/kmd_state_mem.sv @@
// ----------------------------------------------------------------------------
// kmd_state_mem
// Per-key state memory: one write port, one read port with registered data.
// Entries never written since reset read as all zero through valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_state_mem (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          rd_en,
	input  wire  [kmd_pkg::KEY_W-1:0]    rd_addr,
	output kmd_pkg::key_entry_t          rd_data,
	input  wire                          wr_en,
	input  wire  [kmd_pkg::KEY_W-1:0]    wr_addr,
	input  kmd_pkg::key_entry_t          wr_data
);
	import kmd_pkg::*;

	key_entry_t           mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;
	key_entry_t           rd_data_q;
	logic                 rd_vld_q;

	// Storage array, written and read in the same clocked block.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Valid bits stand in for clearing the array at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An entry that was never written reads as its reset value.
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ src/kmd_out_reg.sv @@
// ----------------------------------------------------------------------------
// kmd_out_reg
// Output register of the event channel; builds the six-byte frame of the
// held event.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_out_reg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  kmd_pkg::key_event_t        push_ev,
	output logic                       free,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [kmd_pkg::ID_W-1:0]   key_id,
	output logic                       pressed,
	output logic [7:0]                 checksum,
	output logic [kmd_pkg::FRAME_W-1:0] frame_word,
	output logic                       last_event
);
	import kmd_pkg::*;

	logic       valid_q;
	key_event_t ev_q;

	// The register can take a word when it is empty or its word leaves now.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			ev_q <= push_ev;
		end
	end

	// Frame bytes and their XOR checksum.
	assign out_valid  = valid_q;
	assign key_id     = ev_q.key_id;
	assign pressed    = ev_q.pressed;
	assign last_event = ev_q.last;
	assign checksum   = FRAME_START ^ FRAME_TYPE ^ ev_q.key_id ^ {7'd0, ev_q.pressed}
		^ FRAME_PAD;
	assign frame_word = {FRAME_START, FRAME_TYPE, ev_q.key_id, {7'd0, ev_q.pressed},
		FRAME_PAD, checksum};

endmodule

`default_nettype wire

@@ src/key_matrix_debounce_event_packer_unit.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debounce_event_packer_unit
// Debounces a scanned key matrix and emits one framed event per accepted
// level change.
// ----------------------------------------------------------------------------
// One scan word is taken at a time. The per-key state (last raw level,
// debounced level, time of last raw change) sits in a memory with one read
// and one write port, and the sequencer visits the keys in index order, one
// key per cycle except while a full output register holds back an event.
// Each event leaves as one word; the final event of a scan carries
// last_event. An event is held back until the next one of the scan is found
// or the scan ends, so that last_event is known when it leaves.
// Configuration must be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_event_packer_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	// Configuration write port.
	input  wire                              cfg_we,
	input  wire  [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [kmd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Scan channel.
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [kmd_pkg::SCAN_TIME_W-1:0]  scan_time,
	input  wire  [kmd_pkg::RAW_W-1:0]        raw_keys,
	// Event channel.
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [kmd_pkg::ID_W-1:0]         key_id,
	output logic                             pressed,
	output logic [7:0]                       checksum,
	output logic [kmd_pkg::FRAME_W-1:0]      frame_word,
	output logic                             last_event
);
	import kmd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} seq_state_t;

	seq_state_t           state_q;
	logic [KEY_W-1:0]     key_q;
	logic                 pend_q;
	logic [ID_W-1:0]      pend_id_q;
	logic                 pend_lvl_q;
	logic [TIME_BITS-1:0] time_q;
	logic [RAW_W-1:0]     raw_q;
	logic [DEB_W-1:0]     debounce_time_q;
	logic [ID_W-1:0]      key_id_offset_q;

	logic                 in_acc;
	logic [KEY_COUNT-1:0] raw_ext;
	key_entry_t           ent;
	key_entry_t           wr_data;
	logic                 lvl;
	logic [TIME_BITS-1:0] ctime;
	logic [TIME_BITS-1:0] elapsed;
	logic                 fire;
	logic                 go;
	logic                 last_key;
	logic                 rd_en;
	logic [KEY_W-1:0]     rd_addr;
	logic                 push;
	key_event_t           push_ev;
	logic                 out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q <= DEBOUNCE_RESET;
			key_id_offset_q <= KEY_OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_TIME: debounce_time_q <= cfg_data[DEB_W-1:0];
				REG_KEY_ID_OFFSET: key_id_offset_q <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Raw levels widened to one bit per key; keys beyond the mask read low.
	always_comb begin
		for (int i = 0; i < KEY_COUNT; i++) begin
			raw_ext[i] = (i < RAW_W) ? raw_q[i % RAW_W] : 1'b0;
		end
	end

	// Per-key update of the entry read from the state memory for the current key.
	always_comb begin
		lvl     = raw_ext[key_q];
		ctime   = (lvl != ent.raw_seen) ? time_q : ent.change_time;
		elapsed = time_q - ctime;
		fire    = (CMP_W'(elapsed) >= CMP_W'(debounce_time_q)) && (ent.stable != lvl);
		wr_data.raw_seen    = lvl;
		wr_data.stable      = fire ? lvl : ent.stable;
		wr_data.change_time = ctime;
	end

	// A key advances unless it must hand over a held event to a full register.
	assign go       = (state_q == ST_RUN) && (!fire || !pend_q || out_free);
	assign last_key = (key_q == KEY_W'(KEY_COUNT - 1));
	assign rd_en    = in_acc || (go && !last_key);
	assign rd_addr  = (state_q == ST_IDLE) ? '0 : key_q + KEY_W'(1);

	// The held event leaves when a newer one replaces it or the scan ends.
	assign push = (go && fire && pend_q) || ((state_q == ST_FLUSH) && pend_q && out_free);
	always_comb begin
		push_ev.key_id  = pend_id_q;
		push_ev.pressed = pend_lvl_q;
		push_ev.last    = (state_q == ST_FLUSH);
	end

	// Scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						key_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (go) begin
						if (fire) begin
							pend_q <= 1'b1;
						end
						if (last_key) begin
							state_q <= ST_FLUSH;
						end else begin
							key_q <= key_q + KEY_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scan word and held event payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			time_q <= scan_time[TIME_BITS-1:0];
			raw_q  <= raw_keys;
		end
		if (go && fire) begin
			pend_id_q  <= key_id_offset_q + ID_W'(key_q);
			pend_lvl_q <= lvl;
		end
	end

	kmd_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr_en   (go),
		.wr_addr (key_q),
		.wr_data (wr_data)
	);

	kmd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ev    (push_ev),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_id     (key_id),
		.pressed    (pressed),
		.checksum   (checksum),
		.frame_word (frame_word),
		.last_event (last_event)
	);

	// A word is only pushed when the output register can take it.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("event pushed into a full output register");

	// A read and a write never target the same entry in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && go) |-> (rd_addr != key_q))
		else $error("read and write of the same state entry");

	// No held event is left behind when the block goes idle.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("held event lost at end of scan");

	// A key that waits on the output register stays on the same key.
	a_hold_key: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && !go) |=> ((state_q == ST_RUN) && $stable(key_q)))
		else $error("key sequence advanced while held");

endmodule

`default_nettype wire
